// ===== sv/assert_macros.svh =====
// Assertion macros used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define IMC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// When the trigger holds, the consequence must hold in the next cycle.
`define IMC_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("next-cycle property violated");

`endif

// ===== sv/imc_pkg.sv =====
package imc_pkg;

   // Field and register widths.
   localparam int CODE_W     = 12;
   localparam int PCT_W      = 7;
   localparam int THR_W      = 7;
   localparam int STEP_W     = 8;
   localparam int TPS_W      = 16;
   localparam int PERIOD_W   = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // Duration selection and modes.
   localparam int DUR_CHOICES = 5;
   localparam int DUR_IDX_W   = 3;
   localparam int DUR_MUL_W   = 4;
   localparam int MODE_COUNT  = 3;
   localparam int MODE_W      = 2;
   localparam int BASE_W      = STEP_W + TPS_W;
   localparam int DT_W        = BASE_W + DUR_MUL_W;
   localparam int TICK_W      = 32;

   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HYST   = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_ON_BELOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_OFF_AT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_BELOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_ABOVE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_STEP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SEC  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_PERIOD   = 3'd6;

   // Register reset values.
   localparam logic [THR_W-1:0]    RST_VALVE_ON_BELOW = 7'd35;
   localparam logic [THR_W-1:0]    RST_VALVE_OFF_AT   = 7'd50;
   localparam logic [THR_W-1:0]    RST_ALARM_BELOW    = 7'd25;
   localparam logic [THR_W-1:0]    RST_ALARM_ABOVE    = 7'd65;
   localparam logic [STEP_W-1:0]   RST_DUR_STEP       = 8'd10;
   localparam logic [TPS_W-1:0]    RST_TICKS_PER_SEC  = 16'd1000;
   localparam logic [PERIOD_W-1:0] RST_ALARM_PERIOD   = 24'd1000;
   localparam logic [BASE_W-1:0]   RST_BASE           = BASE_W'(10 * 1000);

   // Percent scaling.
   localparam int SCALE_W = 19;
   localparam int FULL_SCALE = 4095;
   localparam int PERCENT_MAX = 100;

   typedef logic [PCT_W-1:0] pct_type;

endpackage

// ===== sv/imc_percent.sv =====
module imc_percent (
   input  logic [imc_pkg::CODE_W-1:0] code,
   output imc_pkg::pct_type           pct
);

   // Division by 4095 as a multiply-free estimate, x * (1 + 1/4096) / 4096,
   // which is never high and at most one low; a single remainder check fixes it.
   logic [imc_pkg::SCALE_W-1:0] scaled;
   logic [imc_pkg::SCALE_W-1:0] est_sum;
   imc_pkg::pct_type            quot_est;
   logic [imc_pkg::SCALE_W-1:0] quot_prod;
   logic [imc_pkg::SCALE_W-1:0] remainder;

   always_comb begin
      scaled    = imc_pkg::SCALE_W'(code) * imc_pkg::SCALE_W'(imc_pkg::PERCENT_MAX);
      est_sum   = scaled + (scaled >> 12);
      quot_est  = est_sum[imc_pkg::SCALE_W-1:12];
      quot_prod = (imc_pkg::SCALE_W'(quot_est) << 12) - imc_pkg::SCALE_W'(quot_est);
      remainder = scaled - quot_prod;
      if (remainder >= imc_pkg::SCALE_W'(imc_pkg::FULL_SCALE)) begin
         pct = quot_est + imc_pkg::PCT_W'(1);
      end else begin
         pct = quot_est;
      end
   end

endmodule

// ===== sv/irrigation_mode_controller.sv =====
// Irrigation mode controller.
// Each transfer on the request channel (req_valid high, req_stall low) is one
// millisecond tick: a 12-bit moisture sample and three active-low button levels.
// Every request gives exactly one transfer on the response channel carrying the
// valve drive, run state, mode, duration selection, buzzer and moisture percent
// as they stand after that tick.
// The sample is scaled to percent on the way into the input register; the whole
// tick update (buttons, mode behaviour, alarm check) is settled combinationally
// between the input register and the response register. A request passes
// through the input register and then the response register, and one request
// is accepted in every cycle while req_stall is low.
// When the receiver raises rsp_stall the response holds; the input register
// still takes one more request, and req_stall rises only when both stages hold.
// The csr_ port writes the seven settings by index; writes to unused indexes are
// dropped. Writes are to be made only while no tick is in flight; the block does not enforce it.
// Synchronous reset empties both stages, restores the default settings and
// returns the controller to stopped, manual mode, first duration, valve closed.

`include "assert_macros.svh"

module irrigation_mode_controller (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [imc_pkg::CODE_W-1:0]        req_moisture_code,
   input  logic                              req_power_button,
   input  logic                              req_duration_button,
   input  logic                              req_mode_button,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_valve_open,
   output logic                              rsp_running,
   output logic [imc_pkg::MODE_W-1:0]        rsp_mode_sel,
   output logic [imc_pkg::DUR_IDX_W-1:0]     rsp_duration_sel,
   output logic                              rsp_buzzer_on,
   output imc_pkg::pct_type                  rsp_moisture_percent,
   // Settings write port.
   input  logic                              csr_write_en,
   input  logic [imc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // Settings registers. The base duration, step times ticks per second,
   // is kept alongside so that the tick path needs only a small multiply
   // by the selection number.
   // ------------------------------------------------------------------
   logic [imc_pkg::THR_W-1:0]    on_below_ff, off_at_ff, alarm_below_ff, alarm_above_ff;
   logic [imc_pkg::STEP_W-1:0]   step_ff;
   logic [imc_pkg::TPS_W-1:0]    tps_ff;
   logic [imc_pkg::PERIOD_W-1:0] period_ff;
   logic [imc_pkg::BASE_W-1:0]   base_ff;
   logic [imc_pkg::STEP_W-1:0]   base_step;
   logic [imc_pkg::TPS_W-1:0]    base_tps;
   logic [imc_pkg::BASE_W-1:0]   base_in;

   always_comb begin
      base_step = (csr_index == imc_pkg::CSR_DUR_STEP) ?
                  csr_wdata[imc_pkg::STEP_W-1:0] : step_ff;
      base_tps  = (csr_index == imc_pkg::CSR_TICKS_PER_SEC) ?
                  csr_wdata[imc_pkg::TPS_W-1:0] : tps_ff;
      base_in   = imc_pkg::BASE_W'(base_step) * imc_pkg::BASE_W'(base_tps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_below_ff    <= imc_pkg::RST_VALVE_ON_BELOW;
         off_at_ff      <= imc_pkg::RST_VALVE_OFF_AT;
         alarm_below_ff <= imc_pkg::RST_ALARM_BELOW;
         alarm_above_ff <= imc_pkg::RST_ALARM_ABOVE;
         step_ff        <= imc_pkg::RST_DUR_STEP;
         tps_ff         <= imc_pkg::RST_TICKS_PER_SEC;
         period_ff      <= imc_pkg::RST_ALARM_PERIOD;
         base_ff        <= imc_pkg::RST_BASE;
      end else if (csr_write_en) begin
         base_ff <= base_in;
         unique case (csr_index)
            imc_pkg::CSR_VALVE_ON_BELOW: begin
               on_below_ff <= csr_wdata[imc_pkg::THR_W-1:0];
            end
            imc_pkg::CSR_VALVE_OFF_AT: begin
               off_at_ff <= csr_wdata[imc_pkg::THR_W-1:0];
            end
            imc_pkg::CSR_ALARM_BELOW: begin
               alarm_below_ff <= csr_wdata[imc_pkg::THR_W-1:0];
            end
            imc_pkg::CSR_ALARM_ABOVE: begin
               alarm_above_ff <= csr_wdata[imc_pkg::THR_W-1:0];
            end
            imc_pkg::CSR_DUR_STEP: begin
               step_ff <= csr_wdata[imc_pkg::STEP_W-1:0];
            end
            imc_pkg::CSR_TICKS_PER_SEC: begin
               tps_ff <= csr_wdata[imc_pkg::TPS_W-1:0];
            end
            imc_pkg::CSR_ALARM_PERIOD: begin
               period_ff <= csr_wdata[imc_pkg::PERIOD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input stage. The percent is worked out before the register so that
   // the tick update stage only compares it.
   // ------------------------------------------------------------------
   imc_pkg::pct_type pct_in;
   imc_pkg::pct_type s1_pct_ff;
   logic             s1_pwr_ff, s1_dur_ff, s1_mode_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance, accept_in, fire;

   imc_percent u_percent (
      .code (req_moisture_code),
      .pct  (pct_in)
   );

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign accept_in   = req_valid && !req_stall;
   assign fire        = s1_valid_ff && advance;
   assign s1_valid_in = accept_in || (s1_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_pct_ff  <= pct_in;
         s1_pwr_ff  <= req_power_button;
         s1_dur_ff  <= req_duration_button;
         s1_mode_ff <= req_mode_button;
      end
   end

   // ------------------------------------------------------------------
   // Controller state and the tick update.
   // ------------------------------------------------------------------
   logic                            last_pwr_ff, last_dur_ff, last_mode_ff;
   logic [imc_pkg::DUR_IDX_W-1:0]   dur_idx_ff, dur_idx_in;
   logic [imc_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic                            run_ff, run_in;
   logic                            valve_ff, valve_in;
   logic                            buzz_ff, buzz_in;
   logic [imc_pkg::DT_W-1:0]        mcd_ff, mcd_in;
   logic [imc_pkg::TICK_W-1:0]      tick_ff, ltt_ff, ltt_in;
   logic [imc_pkg::PERIOD_W-1:0]    acnt_ff, acnt_in;
   logic [imc_pkg::PERIOD_W:0]      acnt_inc;
   logic [imc_pkg::DT_W-1:0]        dur_ticks;
   logic [imc_pkg::TICK_W-1:0]      since_toggle;
   logic                            busy;

   always_comb begin
      dur_idx_in = dur_idx_ff;
      mode_in    = mode_ff;
      run_in     = run_ff;
      valve_in   = valve_ff;
      buzz_in    = buzz_ff;
      mcd_in     = mcd_ff;
      ltt_in     = ltt_ff;

      // A manual run in progress locks out every button.
      busy = run_ff && (mcd_ff != '0);

      // Duration selection only while stopped.
      if (!busy && !run_ff && last_dur_ff && !s1_dur_ff) begin
         if (dur_idx_ff == imc_pkg::DUR_IDX_W'(imc_pkg::DUR_CHOICES - 1)) begin
            dur_idx_in = '0;
         end else begin
            dur_idx_in = dur_idx_ff + imc_pkg::DUR_IDX_W'(1);
         end
      end

      // Power button toggles between running and stopped.
      if (!busy && last_pwr_ff && !s1_pwr_ff) begin
         if (run_ff) begin
            run_in   = 1'b0;
            valve_in = 1'b0;
            mcd_in   = '0;
         end else begin
            run_in = 1'b1;
         end
      end

      // The duration uses the selection as it stands after this tick's button.
      dur_ticks    = imc_pkg::DT_W'(base_ff) *
                     imc_pkg::DT_W'({1'b0, dur_idx_in} + imc_pkg::DUR_MUL_W'(1));
      since_toggle = tick_ff - ltt_ff;

      if (run_in) begin
         unique case (mode_ff)
            imc_pkg::MODE_MANUAL: begin
               if (mcd_ff == '0) begin
                  // First running tick: load the countdown and open the valve.
                  if (dur_ticks == '0) begin
                     run_in   = 1'b0;
                     valve_in = 1'b0;
                     mcd_in   = '0;
                  end else begin
                     mcd_in   = dur_ticks;
                     valve_in = 1'b1;
                  end
               end else begin
                  mcd_in = mcd_ff - imc_pkg::DT_W'(1);
                  if (mcd_ff == imc_pkg::DT_W'(1)) begin
                     run_in   = 1'b0;
                     valve_in = 1'b0;
                  end
               end
            end
            imc_pkg::MODE_TOGGLE: begin
               if (since_toggle >= imc_pkg::TICK_W'(dur_ticks)) begin
                  ltt_in   = tick_ff;
                  valve_in = !valve_ff;
               end
            end
            imc_pkg::MODE_HYST: begin
               if (s1_pct_ff < on_below_ff) begin
                  valve_in = 1'b1;
               end else if (s1_pct_ff >= off_at_ff) begin
                  valve_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else begin
         valve_in = 1'b0;
      end

      // Mode selection only while stopped, judged after the power button.
      if (!busy && !run_in && last_mode_ff && !s1_mode_ff) begin
         if (mode_ff == imc_pkg::MODE_W'(imc_pkg::MODE_COUNT - 1)) begin
            mode_in = imc_pkg::MODE_MANUAL;
         end else begin
            mode_in = mode_ff + imc_pkg::MODE_W'(1);
         end
      end

      // Periodic alarm check; a fault sounds the buzzer and stops everything.
      acnt_inc = {1'b0, acnt_ff} + (imc_pkg::PERIOD_W + 1)'(1);
      acnt_in  = acnt_inc[imc_pkg::PERIOD_W-1:0];
      if (acnt_inc >= {1'b0, period_ff}) begin
         acnt_in = '0;
         if ((s1_pct_ff > alarm_above_ff) || (s1_pct_ff < alarm_below_ff)) begin
            buzz_in  = 1'b1;
            run_in   = 1'b0;
            valve_in = 1'b0;
            mcd_in   = '0;
         end else begin
            buzz_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pwr_ff  <= 1'b1;
         last_dur_ff  <= 1'b1;
         last_mode_ff <= 1'b1;
         dur_idx_ff   <= '0;
         mode_ff      <= imc_pkg::MODE_MANUAL;
         run_ff       <= 1'b0;
         valve_ff     <= 1'b0;
         buzz_ff      <= 1'b0;
         mcd_ff       <= '0;
         tick_ff      <= '0;
         ltt_ff       <= '0;
         acnt_ff      <= '0;
      end else if (fire) begin
         last_pwr_ff  <= s1_pwr_ff;
         last_dur_ff  <= s1_dur_ff;
         last_mode_ff <= s1_mode_ff;
         dur_idx_ff   <= dur_idx_in;
         mode_ff      <= mode_in;
         run_ff       <= run_in;
         valve_ff     <= valve_in;
         buzz_ff      <= buzz_in;
         mcd_ff       <= mcd_in;
         tick_ff      <= tick_ff + imc_pkg::TICK_W'(1);
         ltt_ff       <= ltt_in;
         acnt_ff      <= acnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_valve_open       <= valve_in;
         rsp_running          <= run_in;
         rsp_mode_sel         <= mode_in;
         rsp_duration_sel     <= dur_idx_in;
         rsp_buzzer_on        <= buzz_in;
         rsp_moisture_percent <= s1_pct_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   logic                         manual_live;
   logic [imc_pkg::PCT_W+2:0]    s1_word;

   assign manual_live = run_ff && valve_ff && (mode_ff == imc_pkg::MODE_MANUAL);
   assign s1_word     = {s1_pct_ff, s1_pwr_ff, s1_dur_ff, s1_mode_ff};

   `IMC_ASSERT_ALWAYS(a_valve_needs_run, clock, reset, !valve_ff || run_ff)
   `IMC_ASSERT_ALWAYS(a_countdown_manual, clock, reset, (mcd_ff == '0) || manual_live)
   `IMC_ASSERT_NEXT(a_held_tick_stays, clock, reset, req_stall, s1_valid_ff && $stable(s1_word))

endmodule
